### hdl/pn2d_pkg.sv
package pn2d_pkg;

  localparam int PERM_ENTRIES = 512;
  localparam int PERM_AW      = $clog2(PERM_ENTRIES);
  localparam int PERM_COPIES  = 6;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = $clog2(Q_DEPTH);

  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [7:0] REG_X_STEP    = 8'd0;
  localparam logic [7:0] REG_Y_STEP    = 8'd1;
  localparam logic [7:0] REG_AMPLITUDE = 8'd2;
  localparam logic [7:0] REG_NARROW    = 8'd3;

  typedef struct packed {
    logic               kind;
    logic [PERM_AW-1:0] ix;
    logic [15:0]        xf;
    logic [7:0]         iy;
    logic [15:0]        yf;
    logic [8:0]         table_index;
    logic [7:0]         table_value;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t data;
  } push_t;

  typedef struct packed {
    logic  valid;
    logic  full;
    qent_t head;
  } qstat_t;

  // shift right by k, rounding half away from zero
  function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] v,
                                                 input logic [5:0] k);
    logic signed [63:0] half;
    half = 64'sd1 <<< (k - 6'd1);
    if (v >= 64'sd0) return (v + half) >>> k;
    else return -((-v + half) >>> k);
  endfunction

  function automatic logic signed [19:0] grad(input logic [2:0] h,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y);
    logic signed [19:0] xe;
    logic signed [19:0] ye;
    xe = 20'(x);
    ye = 20'(y);
    case (h)
      3'd0:    return xe;
      3'd1:    return -xe;
      3'd2:    return ye;
      3'd3:    return -ye;
      3'd4:    return xe + ye;
      3'd5:    return -xe + ye;
      3'd6:    return xe - ye;
      default: return -xe - ye;
    endcase
  endfunction

endpackage

### hdl/pn2d_if.sv
interface pn2d_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] px;
  logic [15:0] py;
  logic [8:0]  table_index;
  logic [7:0]  table_value;
  modport source (output valid, kind, px, py, table_index, table_value, input ready);
  modport sink   (input valid, kind, px, py, table_index, table_value, output ready);
endinterface

interface pn2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

interface pn2d_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [23:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### hdl/pn2d_front.sv
module pn2d_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [15:0]           in_px,
  input  logic [15:0]           in_py,
  input  logic [8:0]            in_table_index,
  input  logic [7:0]            in_table_value,
  input  logic [23:0]           x_step,
  input  logic [23:0]           y_step,
  input  pn2d_pkg::qstat_t      qstat,
  output pn2d_pkg::push_t       qpush
);

  logic        fv_r;
  logic        kind_r;
  logic [15:0] px_r;
  logic [15:0] py_r;
  logic [8:0]  tidx_r;
  logic [7:0]  tval_r;
  logic [39:0] xq;
  logic [39:0] yq;
  logic        take;

  assign in_ready = !fv_r || !qstat.full;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (take) begin
      fv_r <= 1'b1;
    end else if (!qstat.full) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= in_kind;
      px_r   <= in_px;
      py_r   <= in_py;
      tidx_r <= in_table_index;
      tval_r <= in_table_value;
    end
  end

  assign xq = 40'(px_r) * 40'(x_step);
  assign yq = 40'(py_r) * 40'(y_step);

  always_comb begin
    qpush.push             = fv_r && !qstat.full;
    qpush.data.kind        = kind_r;
    qpush.data.ix          = xq[16 +: pn2d_pkg::PERM_AW];
    qpush.data.xf          = xq[15:0];
    qpush.data.iy          = yq[23:16];
    qpush.data.yf          = yq[15:0];
    qpush.data.table_index = tidx_r;
    qpush.data.table_value = tval_r;
  end

endmodule

### hdl/pn2d_queue.sv
module pn2d_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  pn2d_pkg::push_t   qpush,
  input  logic              pop,
  output pn2d_pkg::qstat_t  qstat
);

  pn2d_pkg::qent_t           ent_r [pn2d_pkg::Q_DEPTH];
  logic [pn2d_pkg::Q_AW-1:0] wp_r;
  logic [pn2d_pkg::Q_AW-1:0] rp_r;
  logic [pn2d_pkg::Q_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (qpush.push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (pn2d_pkg::Q_AW+1)'(qpush.push) - (pn2d_pkg::Q_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (qpush.push) ent_r[wp_r] <= qpush.data;
  end

  always_comb begin
    qstat.valid = cnt_r != '0;
    qstat.full  = cnt_r == (pn2d_pkg::Q_AW+1)'(pn2d_pkg::Q_DEPTH);
    qstat.head  = ent_r[rp_r];
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !qpush.push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> qstat.valid) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (pn2d_pkg::Q_AW+1)'(pn2d_pkg::Q_DEPTH)) else $error("queue count out of range");

endmodule

### hdl/pn2d_back.sv
module pn2d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pn2d_pkg::qstat_t    qstat,
  output logic                pop,
  input  logic [23:0]         amplitude,
  input  logic                narrow_output,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_sample
);

  localparam int AW = pn2d_pkg::PERM_AW;
  localparam int NC = pn2d_pkg::PERM_COPIES;

  logic en;
  logic wr_en;
  logic [AW-1:0] waddr;

  logic [7:0]    perm_mem [NC][pn2d_pkg::PERM_ENTRIES];
  logic [AW-1:0] raddr [NC];
  logic [7:0]    rdata_r [NC];

  // stage 1
  logic          v1_r;
  logic [AW-1:0] ix1_r;
  logic [15:0]   xf1_r, yf1_r;
  logic [31:0]   t2x1_r, t2y1_r;
  // stage 2
  logic          v2_r;
  logic [15:0]   xf2_r, yf2_r;
  logic [31:0]   t3x2_r, t3y2_r;
  logic [20:0]   plx2_r, ply2_r;
  // stage 3
  logic               v3_r;
  logic [16:0]        u3_r, v3f_r;
  logic signed [19:0] g00_r, g10_r, g01_r, g11_r;
  // stage 4
  logic               v4_r;
  logic [16:0]        v4f_r;
  logic signed [23:0] x0_r, x1_r;
  // stage 5
  logic               v5_r;
  logic signed [23:0] n5_r;
  // stage 6
  logic               v6_r;
  logic signed [49:0] p6_r;
  // output
  logic               ov_r;
  logic signed [15:0] os_r;

  logic [AW-1:0] ca, cb, cc, cd;
  logic [48:0]   t3x_full, t3y_full;
  logic [34:0]   six_x, six_y;
  logic [18:0]   p6x, p6y;
  logic [52:0]   fx_full, fy_full;
  logic signed [17:0] gx0, gx1, gy0, gy1;
  logic signed [63:0] lr0, lr1, lr2, srnd;
  logic signed [15:0] sat;

  assign en    = !ov_r || out_ready;
  assign pop   = en && qstat.valid;
  assign wr_en = pop && (qstat.head.kind == pn2d_pkg::KIND_TABLE) &&
                 (32'(qstat.head.table_index) < pn2d_pkg::PERM_ENTRIES);
  assign waddr = AW'(qstat.head.table_index);

  // corner hashes, column wraps modulo table size
  assign ca = ix1_r + AW'(rdata_r[0]);
  assign cb = ca + 1'b1;
  assign cc = ix1_r + AW'(rdata_r[1]);
  assign cd = cc + 1'b1;

  always_comb begin
    raddr[0] = AW'(qstat.head.iy);
    raddr[1] = AW'({1'b0, qstat.head.iy} + 9'd1);
    raddr[2] = ca;
    raddr[3] = cb;
    raddr[4] = cc;
    raddr[5] = cd;
  end

  // every copy sees every write; reads are read-before-write
  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      if (wr_en) perm_mem[c][waddr] <= qstat.head.table_value;
      if (en) rdata_r[c] <= perm_mem[c][raddr[c]];
    end
  end

  always_comb begin
    t3x_full = 49'(t2x1_r) * 49'(xf1_r) + 49'd32768;
    t3y_full = 49'(t2y1_r) * 49'(yf1_r) + 49'd32768;
    six_x    = {1'b0, t2x1_r, 2'b0} + {2'b0, t2x1_r, 1'b0} + 35'd32768;
    six_y    = {1'b0, t2y1_r, 2'b0} + {2'b0, t2y1_r, 1'b0} + 35'd32768;
    p6x      = six_x[34:16];
    p6y      = six_y[34:16];
    fx_full  = 53'(t3x2_r) * 53'(plx2_r) + 53'h80000000;
    fy_full  = 53'(t3y2_r) * 53'(ply2_r) + 53'h80000000;
    gx0      = $signed({2'b0, xf2_r});
    gx1      = gx0 - 18'sd65536;
    gy0      = $signed({2'b0, yf2_r});
    gy1      = gy0 - 18'sd65536;
    lr0      = pn2d_pkg::shr_rnd(64'($signed({1'b0, u3_r}) * 21'(g10_r - g00_r)), 6'd16);
    lr1      = pn2d_pkg::shr_rnd(64'($signed({1'b0, u3_r}) * 21'(g11_r - g01_r)), 6'd16);
    lr2      = pn2d_pkg::shr_rnd(64'($signed({1'b0, v4f_r}) * 25'(x1_r - x0_r)), 6'd16);
    srnd     = pn2d_pkg::shr_rnd(64'(p6_r), 6'd24);
    if (narrow_output) begin
      if (srnd < -64'sd128) sat = -16'sd128;
      else if (srnd > 64'sd127) sat = 16'sd127;
      else sat = 16'(srnd);
    end else begin
      if (srnd < -64'sd32768) sat = -16'sd32768;
      else if (srnd > 64'sd32767) sat = 16'sd32767;
      else sat = 16'(srnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v1_r <= pop && (qstat.head.kind == pn2d_pkg::KIND_PIXEL);
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      ov_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ix1_r  <= qstat.head.ix;
      xf1_r  <= qstat.head.xf;
      yf1_r  <= qstat.head.yf;
      t2x1_r <= 32'(qstat.head.xf) * 32'(qstat.head.xf);
      t2y1_r <= 32'(qstat.head.yf) * 32'(qstat.head.yf);

      xf2_r  <= xf1_r;
      yf2_r  <= yf1_r;
      t3x2_r <= t3x_full[47:16];
      t3y2_r <= t3y_full[47:16];
      plx2_r <= 21'(p6x) + 21'd655360 - 21'({xf1_r, 4'b0} - 20'(xf1_r));
      ply2_r <= 21'(p6y) + 21'd655360 - 21'({yf1_r, 4'b0} - 20'(yf1_r));

      u3_r  <= fx_full[48:32];
      v3f_r <= fy_full[48:32];
      g00_r <= pn2d_pkg::grad(rdata_r[2][2:0], gx0, gy0);
      g10_r <= pn2d_pkg::grad(rdata_r[3][2:0], gx1, gy0);
      g01_r <= pn2d_pkg::grad(rdata_r[4][2:0], gx0, gy1);
      g11_r <= pn2d_pkg::grad(rdata_r[5][2:0], gx1, gy1);

      v4f_r <= v3f_r;
      x0_r  <= 24'(g00_r) + 24'(lr0);
      x1_r  <= 24'(g01_r) + 24'(lr1);

      n5_r <= x0_r + 24'(lr2);

      p6_r <= 50'(n5_r) * $signed({26'd0, amplitude});

      os_r <= sat;
    end
  end

  assign out_valid  = ov_r;
  assign out_sample = os_r;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r, v6_r})) else $error("pipe moved on stall");
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && v6_r |=> ov_r) else $error("result lost at output");
  a_write_not_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> !v1_r) else $error("table write entered sample pipe");

endmodule

### hdl/perlin_noise_2d_pixel_unit.sv
// 2D gradient noise, one sample per pixel. Table writes (kind 0) load the 512-byte permutation
// store and give no result; pixel items (kind 1) give one saturated int16 (or int8 in narrow
// mode) sample. Throughput is one item per clock, limited by nothing but output back-pressure:
// the front multiplier stage feeds a 4-entry queue, and the back pipeline keeps six copies of
// the permutation store so both row reads and all four corner reads occur whenever the pipe
// advances. A pixel item goes through the front registers, the queue and the back stages.
// Registers are written through the cfg channel; the user must write them only while the unit
// is idle (not enforced by the unit); store entries read before being written are undefined.
module perlin_noise_2d_pixel_unit (
  input  logic       clk,
  input  logic       rst_n,
  pn2d_in_if.sink    in_ch,
  pn2d_out_if.source out_ch,
  pn2d_cfg_if.sink   cfg_ch
);

  logic [23:0] x_step_r;
  logic [23:0] y_step_r;
  logic [23:0] amplitude_r;
  logic        narrow_r;

  pn2d_pkg::push_t  qpush;
  pn2d_pkg::qstat_t qstat;
  logic             pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_step_r    <= 24'd1024;
      y_step_r    <= 24'd1024;
      amplitude_r <= 24'd256;
      narrow_r    <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        pn2d_pkg::REG_X_STEP:    x_step_r    <= cfg_ch.wdata;
        pn2d_pkg::REG_Y_STEP:    y_step_r    <= cfg_ch.wdata;
        pn2d_pkg::REG_AMPLITUDE: amplitude_r <= cfg_ch.wdata;
        pn2d_pkg::REG_NARROW:    narrow_r    <= cfg_ch.wdata[0];
        default: ;
      endcase
    end
  end

  pn2d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_kind        (in_ch.kind),
    .in_px          (in_ch.px),
    .in_py          (in_ch.py),
    .in_table_index (in_ch.table_index),
    .in_table_value (in_ch.table_value),
    .x_step         (x_step_r),
    .y_step         (y_step_r),
    .qstat          (qstat),
    .qpush          (qpush)
  );

  pn2d_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qpush (qpush),
    .pop   (pop),
    .qstat (qstat)
  );

  pn2d_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .qstat         (qstat),
    .pop           (pop),
    .amplitude     (amplitude_r),
    .narrow_output (narrow_r),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_sample    (out_ch.sample)
  );

endmodule
